### rtl/pcfl_pkg.sv
// Package for the pin-change frame logger: types, frame constants and the
// snapshot packing and frame byte selection shared by the front and back parts.
// No dependencies.
`timescale 1ns / 1ps

package pcfl_pkg;

    localparam int SNAP_BYTES  = 9;
    localparam int FRAME_BYTES = 25;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0] CH_START   = 8'h53; // 'S'
    localparam logic [7:0] CH_DOT     = 8'h2E; // '.'
    localparam logic [7:0] CH_INIT    = 8'h49; // 'I'
    localparam logic [7:0] CH_CHANGE  = 8'h54; // 'T'
    localparam logic [7:0] CH_END     = 8'h45; // 'E'
    localparam logic [7:0] PAYLOAD_LEN = 8'd14;

    localparam logic [31:0] LIMIT_RESET = 32'd1800000000;

    localparam logic [IDX_W-1:0] IDX_SNAP0  = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_BYTES - 1);

    localparam int TDATA_IN_W = 120;

    typedef logic [SNAP_BYTES-1:0][7:0] snap_t;

    typedef struct packed {
        snap_t       snap;
        logic [7:0]  marker;
        logic [31:0] ts;
    } frame_desc_t;

    typedef struct packed {
        logic [7:0]  port_a;
        logic [7:0]  port_b;
        logic [7:0]  port_c;
        logic [7:0]  port_d;
        logic [7:0]  port_e;
        logic [7:0]  port_f;
        logic [7:0]  port_g;
        logic [7:0]  port_h;
        logic [7:0]  port_j;
        logic [7:0]  port_k;
        logic [7:0]  port_l;
        logic [31:0] timestamp_us;
    } sample_t;

    function automatic sample_t unpack_sample(input logic [TDATA_IN_W-1:0] d);
        sample_t s;
        s.port_a       = d[7:0];
        s.port_b       = d[15:8];
        s.port_c       = d[23:16];
        s.port_d       = d[31:24];
        s.port_e       = d[39:32];
        s.port_f       = d[47:40];
        s.port_g       = d[55:48];
        s.port_h       = d[63:56];
        s.port_j       = d[71:64];
        s.port_k       = d[79:72];
        s.port_l       = d[87:80];
        s.timestamp_us = d[119:88];
        return s;
    endfunction

    function automatic snap_t pack_snapshot(input sample_t s);
        snap_t r;
        r[0] = s.port_a;
        r[1] = s.port_b;
        r[2] = s.port_c;
        r[3] = {s.port_d[7], s.port_e[5:3], s.port_d[3:0]};
        r[4] = s.port_f;
        r[5] = {s.port_j[1], s.port_h[6:3], s.port_j[0], s.port_h[1:0]};
        r[6] = s.port_k;
        r[7] = s.port_l;
        r[8] = {s.port_g[0], s.port_g[1], s.port_g[2], s.port_g[5], 4'b0000};
        return r;
    endfunction

    function automatic logic [7:0] frame_byte_at(input frame_desc_t d,
                                                 input logic [IDX_W-1:0] idx);
        logic [7:0]       b;
        logic [IDX_W-1:0] rel;
        rel = idx - IDX_SNAP0;
        unique case (idx) inside
            5'd0:                         b = CH_START;
            5'd1, 5'd2, 5'd3, 5'd4:       b = CH_DOT;
            5'd5:                         b = PAYLOAD_LEN;
            [5'd6:5'd14]:                 b = d.snap[rel[3:0]];
            5'd15:                        b = d.marker;
            [5'd16:5'd19]:                b = d.ts[idx[1:0]*8 +: 8];
            [5'd20:5'd23]:                b = CH_DOT;
            5'd24:                        b = CH_END;
            default:                      b = CH_END;
        endcase
        return b;
    endfunction

endpackage

### rtl/pin_change_frame_logger.sv
// Top level of the pin-change frame logger: configuration port, front part,
// frame queue and byte serializer. Depends on pcfl_pkg, pcfl_front,
// pcfl_queue and pcfl_back.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one sample word per handshake: eleven port bytes and a
//   microsecond timestamp. m_axis carries frame bytes, tlast on the closing
//   'E'. A sample that changes the snapshot (or the first one after reset or
//   restart) yields a 25-byte frame; other samples yield nothing.
//   A sample is taken whenever the two-entry frame queue has room; its
//   frame bytes pass the queue entry, the serializer's frame register and
//   the output byte register. The serializer sends one byte per cycle
//   while the receiver is ready, so frames leave back to back; unchanged
//   samples pass at one per cycle while the queue is not full.
//   When the receiver stalls, the output byte holds and the queue fills;
//   s_axis_tready drops once it is full.
//   Reset clears the queue, the serializer and the started flag and loads
//   restart_limit with 1800000000; the stored snapshot needs no clearing.
//   APB register 0 (address 0) is restart_limit; write it only while idle.
module pin_change_frame_logger
    import pcfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // sample stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // port_a, port_b, port_c, port_d, port_e, port_f, port_g, port_h,
    // port_j, port_k, port_l (8 bits each), timestamp_us (32 bits)
    input  logic [TDATA_IN_W-1:0] s_axis_tdata,
    // frame stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // frame_byte
    output logic [7:0]            m_axis_tdata,
    // last_byte
    output logic                  m_axis_tlast
);

    logic [31:0] restart_limit_reg, restart_limit_next;
    logic        cfg_write;
    logic        q_push, q_full, q_pop, q_valid;
    frame_desc_t q_wdata, q_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? restart_limit_reg : '0;

    always_comb
    begin
        restart_limit_next = restart_limit_reg;
        if (cfg_write)
            restart_limit_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restart_limit_reg <= LIMIT_RESET;
        else
            restart_limit_reg <= restart_limit_next;
    end

    pcfl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_data       (s_axis_tdata),
        .restart_limit (restart_limit_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    pcfl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_rdata)
    );

    pcfl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### rtl/pcfl_front.sv
// Front part of the frame logger: accepts samples, packs and compares snapshots,
// decides on initial, change and restart, and pushes frame words into the queue.
// Depends on pcfl_pkg.
`timescale 1ns / 1ps

module pcfl_front
    import pcfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TDATA_IN_W-1:0] in_data,
    input  logic [31:0]           restart_limit,
    input  logic                  q_full,
    output logic                  q_push,
    output frame_desc_t           q_data
);

    logic    started_reg, started_next;
    snap_t   prev_reg, prev_next;
    sample_t smp;
    snap_t   snap;
    logic    accept;
    logic    changed;

    assign smp      = unpack_sample(in_data);
    assign snap     = pack_snapshot(smp);
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign changed  = (snap != prev_reg);

    always_comb
    begin
        started_next = started_reg;
        prev_next    = prev_reg;
        q_push       = 1'b0;
        q_data.snap  = snap;
        q_data.marker = CH_CHANGE;
        q_data.ts    = smp.timestamp_us;
        if (accept)
        begin
            if (!started_reg)
            begin
                q_push        = 1'b1;
                q_data.marker = CH_INIT;
                q_data.ts     = '0;
                prev_next     = snap;
                started_next  = 1'b1;
            end
            else
            begin
                if (changed)
                begin
                    q_push    = 1'b1;
                    prev_next = snap;
                end
                if (smp.timestamp_us > restart_limit)
                    started_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            started_reg <= 1'b0;
        else
            started_reg <= started_next;
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
    end

endmodule

### rtl/pcfl_queue.sv
// Short queue of frame words between the front and back parts.
// Depends on pcfl_pkg.
`timescale 1ns / 1ps

module pcfl_queue
    import pcfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_desc_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        valid,
    output frame_desc_t pop_data
);

    frame_desc_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic                    do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/pcfl_back.sv
// Back part of the frame logger: takes frame words from the queue and sends
// the 25 frame bytes through a registered output stage, one per cycle while the receiver is ready.
// Depends on pcfl_pkg.
`timescale 1ns / 1ps

module pcfl_back
    import pcfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  frame_desc_t q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_data,
    output logic        out_last
);

    frame_desc_t      desc_reg, desc_next;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       data_reg, data_next;
    logic             last_reg, last_next;
    logic             out_load;
    logic             at_last;

    assign out_load = busy_reg && (!valid_reg || out_ready);
    assign at_last  = (idx_reg == IDX_LAST);
    assign q_pop    = q_valid && (!busy_reg || (out_load && at_last));

    always_comb
    begin
        desc_next  = desc_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (out_load)
        begin
            valid_next = 1'b1;
            data_next  = frame_byte_at(desc_reg, idx_reg);
            last_next  = at_last;
            idx_next   = idx_reg + 1'b1;
            if (at_last)
                busy_next = 1'b0;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (q_pop)
        begin
            desc_next = q_data;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule
